FILE: rtl/bucket_hash_linear_probe_insert_assert.svh
// Assertion macros for the bucket hash table RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef BUCKET_HASH_LINEAR_PROBE_INSERT_ASSERT_SVH
`define BUCKET_HASH_LINEAR_PROBE_INSERT_ASSERT_SVH

// The condition must hold at every clock edge.
`define BHLP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define BHLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bhlp_pkg.sv
// Shared types and constants for the bucket hash table.
// No dependencies; every other file but the assertion header uses this package.
`timescale 1ns / 1ps

package bhlp_pkg;

  localparam int BUCKETS_DEF = 11;
  localparam int KEY_W       = 31;
  localparam int ROW_W       = 4;
  localparam int STATUS_W    = 2;

  // The hash takes the key apart HASH_DIGIT bits per cycle.
  localparam int HASH_DIGIT  = 4;
  localparam int HASH_STEPS  = (KEY_W + HASH_DIGIT - 1) / HASH_DIGIT;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ROW_READ = 2'd2;

  // One table row as stored in memory.
  typedef struct packed {
    logic             v1;
    logic [KEY_W-1:0] k1;
    logic             v0;
    logic [KEY_W-1:0] k0;
  } bhlp_row_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HOME,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_READ_RD,
    S_READ_OUT
  } bhlp_state_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic hash_step;
    logic probe_home;
    logic probe_adv;
    logic rd_probe;
    logic rd_row;
    logic wr_slot;
    logic load_ins;
    logic load_ovf;
    logic load_read;
  } bhlp_cmd_t;

  typedef struct packed {
    logic in_mode;
    logic row_last;
    logic hash_last;
    logic probe_last;
    logic slot0_free;
    logic slot1_free;
    logic out_free;
  } bhlp_sts_t;

endpackage

FILE: rtl/bhlp_if.sv
// Valid/ready channel interfaces for the bucket hash table.
// Depends on bhlp_pkg for field widths.
`timescale 1ns / 1ps

interface bhlp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [bhlp_pkg::KEY_W-1:0]  key;
  logic [bhlp_pkg::ROW_W-1:0]  row;

  modport source (output valid, output mode, output key, output row, input ready);
  modport sink   (input valid, input mode, input key, input row, output ready);
endinterface

interface bhlp_out_if;
  logic                          valid;
  logic                          ready;
  logic [bhlp_pkg::STATUS_W-1:0] status;
  logic [bhlp_pkg::ROW_W-1:0]    placed_row;
  logic                          placed_slot;
  logic                          slot0_valid;
  logic [bhlp_pkg::KEY_W-1:0]    slot0_key;
  logic                          slot1_valid;
  logic [bhlp_pkg::KEY_W-1:0]    slot1_key;

  modport source (output valid, output status, output placed_row, output placed_slot,
                  output slot0_valid, output slot0_key, output slot1_valid,
                  output slot1_key, input ready);
  modport sink   (input valid, input status, input placed_row, input placed_slot,
                  input slot0_valid, input slot0_key, input slot1_valid,
                  input slot1_key, output ready);
endinterface

FILE: rtl/bhlp_datapath.sv
// Datapath of the bucket hash table: input capture, digit-serial hash,
// probe counters, row memory and the output register. Depends on bhlp_pkg.
`timescale 1ns / 1ps

module bhlp_datapath #(
  parameter int BUCKETS = bhlp_pkg::BUCKETS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bhlp_pkg::bhlp_cmd_t           cmd,
  output bhlp_pkg::bhlp_sts_t           sts,
  input  logic                          in_mode,
  input  logic [bhlp_pkg::KEY_W-1:0]    in_key,
  input  logic [bhlp_pkg::ROW_W-1:0]    in_row,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [bhlp_pkg::STATUS_W-1:0] out_status,
  output logic [bhlp_pkg::ROW_W-1:0]    out_placed_row,
  output logic                          out_placed_slot,
  output logic                          out_slot0_valid,
  output logic [bhlp_pkg::KEY_W-1:0]    out_slot0_key,
  output logic                          out_slot1_valid,
  output logic [bhlp_pkg::KEY_W-1:0]    out_slot1_key
);

  import bhlp_pkg::*;

  localparam int AW  = $clog2(BUCKETS);
  localparam int RW  = AW + 1;
  localparam int KPW = HASH_STEPS * HASH_DIGIT;
  localparam int HCW = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;

  bhlp_row_t              mem [BUCKETS];
  bhlp_row_t              rdata_r;
  bhlp_row_t              upd_row;
  bhlp_row_t              wr_data;

  logic [KEY_W-1:0]       key_r;
  logic [ROW_W-1:0]       row_r;
  logic [KPW-1:0]         kr_r;
  logic [RW-1:0]          rem_r;
  logic [RW-1:0]          rem_nxt;
  logic [HCW-1:0]         hcnt_r;
  logic [AW-1:0]          probe_r;
  logic [AW-1:0]          probe_nxt;
  logic [AW-1:0]          pcnt_r;
  logic [AW-1:0]          row_addr;
  logic [AW-1:0]          rd_addr;
  logic [AW+ROW_W-1:0]    row_ext;
  logic [AW+ROW_W-1:0]    probe_ext;
  logic                   row_ok;
  logic                   rd_en;
  logic                   wr_en;
  logic [HASH_DIGIT-1:0]  digit;

  logic                   out_valid_r;
  logic [STATUS_W-1:0]    status_r;
  logic [ROW_W-1:0]       prow_r;
  logic                   pslot_r;
  logic                   v0_r;
  logic [KEY_W-1:0]       k0_r;
  logic                   v1_r;
  logic [KEY_W-1:0]       k1_r;

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r  <= in_key;
      row_r  <= in_row;
    end
  end

  // Remainder by BUCKETS, one digit of the key per cycle. The partial
  // remainder stays below BUCKETS, so one compare and subtract per bit.
  assign digit = kr_r[KPW-1 -: HASH_DIGIT];

  always_comb begin
    logic [RW-1:0] t;
    t = rem_r;
    for (int i = 0; i < HASH_DIGIT; i++) begin
      t = {t[RW-2:0], digit[HASH_DIGIT-1-i]};
      if (t >= RW'(BUCKETS)) begin
        t = t - RW'(BUCKETS);
      end
    end
    rem_nxt = t;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kr_r   <= KPW'(in_key);
      rem_r  <= '0;
      hcnt_r <= '0;
    end else if (cmd.hash_step) begin
      kr_r   <= {kr_r[KPW-HASH_DIGIT-1:0], HASH_DIGIT'(0)};
      rem_r  <= rem_nxt;
      hcnt_r <= hcnt_r + 1'b1;
    end
  end

  // Probe row pointer; it also walks the rows during the clearing pass.
  assign probe_nxt = (probe_r == AW'(BUCKETS - 1)) ? '0 : probe_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else if (cmd.probe_home) begin
      probe_r <= rem_r[AW-1:0];
    end else if (cmd.probe_adv) begin
      probe_r <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_home) begin
      pcnt_r <= '0;
    end else if (cmd.probe_adv) begin
      pcnt_r <= pcnt_r + 1'b1;
    end
  end

  // Row memory, one write and one registered read per cycle.
  assign row_ext  = (AW + ROW_W)'(row_r);
  assign row_addr = row_ext[AW-1:0];
  assign row_ok   = 32'(row_r) < 32'(BUCKETS);
  assign rd_en    = cmd.rd_probe | (cmd.rd_row & row_ok);
  assign rd_addr  = cmd.rd_row ? row_addr : probe_r;

  always_comb begin
    upd_row = rdata_r;
    if (!rdata_r.v0) begin
      upd_row.v0 = 1'b1;
      upd_row.k0 = key_r;
    end else begin
      upd_row.v1 = 1'b1;
      upd_row.k1 = key_r;
    end
  end

  assign wr_en   = cmd.clr_wr | cmd.wr_slot;
  assign wr_data = cmd.clr_wr ? '0 : upd_row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[probe_r] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Output register.
  assign probe_ext = (AW + ROW_W)'(probe_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_ins || cmd.load_ovf || cmd.load_read) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ins) begin
      status_r <= ST_INSERTED;
      prow_r   <= probe_ext[ROW_W-1:0];
      pslot_r  <= rdata_r.v0;
      v0_r     <= 1'b0;
      k0_r     <= '0;
      v1_r     <= 1'b0;
      k1_r     <= '0;
    end else if (cmd.load_ovf) begin
      status_r <= ST_OVERFLOW;
      prow_r   <= '0;
      pslot_r  <= 1'b0;
      v0_r     <= 1'b0;
      k0_r     <= '0;
      v1_r     <= 1'b0;
      k1_r     <= '0;
    end else if (cmd.load_read) begin
      status_r <= ST_ROW_READ;
      prow_r   <= row_r;
      pslot_r  <= 1'b0;
      v0_r     <= row_ok & rdata_r.v0;
      k0_r     <= (row_ok & rdata_r.v0) ? rdata_r.k0 : '0;
      v1_r     <= row_ok & rdata_r.v1;
      k1_r     <= (row_ok & rdata_r.v1) ? rdata_r.k1 : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_placed_row  = prow_r;
  assign out_placed_slot = pslot_r;
  assign out_slot0_valid = v0_r;
  assign out_slot0_key   = k0_r;
  assign out_slot1_valid = v1_r;
  assign out_slot1_key   = k1_r;

  // Status toward the controller.
  always_comb begin
    sts            = '0;
    sts.in_mode    = in_mode;
    sts.row_last   = (probe_r == AW'(BUCKETS - 1));
    sts.hash_last  = (hcnt_r == HCW'(HASH_STEPS - 1));
    sts.probe_last = (pcnt_r == AW'(BUCKETS - 1));
    sts.slot0_free = !rdata_r.v0;
    sts.slot1_free = !rdata_r.v1;
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

FILE: rtl/bhlp_ctrl.sv
// Controller state machine of the bucket hash table.
// Depends on bhlp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bucket_hash_linear_probe_insert_assert.svh"

module bhlp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bhlp_pkg::bhlp_sts_t sts,
  output bhlp_pkg::bhlp_cmd_t cmd
);

  import bhlp_pkg::*;

  bhlp_state_t state_r;
  bhlp_state_t state_nxt;

  logic        load_any;
  logic        row_full;
  logic        ovf_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr    = 1'b1;
        cmd.probe_adv = 1'b1;
        if (sts.row_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.in_mode ? S_READ_RD : S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) begin
          state_nxt = S_HOME;
        end
      end
      S_HOME: begin
        cmd.probe_home = 1'b1;
        state_nxt      = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        cmd.rd_probe = 1'b1;
        state_nxt    = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (sts.slot0_free || sts.slot1_free) begin
          if (sts.out_free) begin
            cmd.wr_slot  = 1'b1;
            cmd.load_ins = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (sts.probe_last) begin
          if (sts.out_free) begin
            cmd.load_ovf = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.probe_adv = 1'b1;
          state_nxt     = S_PROBE_RD;
        end
      end
      S_READ_RD: begin
        cmd.rd_row = 1'b1;
        state_nxt  = S_READ_OUT;
      end
      S_READ_OUT: begin
        if (sts.out_free) begin
          cmd.load_read = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign load_any = cmd.load_ins || cmd.load_ovf || cmd.load_read;
  assign row_full = !sts.slot0_free && !sts.slot1_free;
  assign ovf_ok   = sts.probe_last && row_full;

  `BHLP_ASSERT_IMP(a_load_needs_room, load_any, sts.out_free, "result loaded into a busy output")
  `BHLP_ASSERT_IMP(a_write_has_free_slot, cmd.wr_slot, !row_full, "insert into a full row")
  `BHLP_ASSERT_IMP(a_ovf_after_sweep, cmd.load_ovf, ovf_ok, "overflow before a full sweep")

endmodule

FILE: rtl/bucket_hash_linear_probe_insert.sv
// Top level of the bucket hash table with linear probing.
// Depends on bhlp_pkg, bhlp_if, bhlp_ctrl and bhlp_datapath.
`timescale 1ns / 1ps

// Hash table of BUCKETS rows with two key slots per row, held in a dual-port
// row memory. An insert item hashes its key as key modulo BUCKETS, then probes
// rows from that home row upward, wrapping to row 0, and stores the key in the
// first free slot, slot 0 before slot 1; duplicates are stored again. When all
// BUCKETS rows are full the table is left unchanged and overflow is reported.
// A read item returns both slots of one row; a row number of BUCKETS or more
// reads as empty. Exactly one result item is produced per input item.
// Operation: after reset the block sweeps the memory to clear every row, with
// in_if.ready low. An insert then captures the item, hashes the key four bits
// at a time, loads the home row, and for each probed row (1 to BUCKETS rows
// are probed) reads the row from the memory port and checks it in the following
// cycle. A read captures the item, reads the row and loads the output register.
// Items are handled one at a time; the result sits in an output register, so a
// finished result may wait for out_if.ready while the next item is already
// accepted and worked on.

module bucket_hash_linear_probe_insert #(
  parameter int BUCKETS = bhlp_pkg::BUCKETS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bhlp_in_if.sink      in_if,
  bhlp_out_if.source   out_if
);

  import bhlp_pkg::*;

  bhlp_cmd_t cmd;
  bhlp_sts_t sts;

  // The state machine issues commands; the datapath answers with status.
  bhlp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bhlp_datapath #(
    .BUCKETS (BUCKETS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_if.mode),
    .in_key          (in_if.key),
    .in_row          (in_if.row),
    .out_ready       (out_if.ready),
    .out_valid       (out_if.valid),
    .out_status      (out_if.status),
    .out_placed_row  (out_if.placed_row),
    .out_placed_slot (out_if.placed_slot),
    .out_slot0_valid (out_if.slot0_valid),
    .out_slot0_key   (out_if.slot0_key),
    .out_slot1_valid (out_if.slot1_valid),
    .out_slot1_key   (out_if.slot1_key)
  );

endmodule
